// ===== sv/npcs_pkg.sv =====
// Package for the nearest palette color search unit.
// Sizes, action codes and controller/datapath interface structs; no dependencies.
package npcs_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int FIELD_IDX_W  = 8;
    localparam int COLOR_W      = 8;
    localparam int SQ_W         = 2 * COLOR_W;
    localparam int DIST_W       = SQ_W + 2;

    // all ones lies above the largest distance 3*255*255, so entry 0 always wins first
    localparam logic [DIST_W-1:0] BOUND_INIT = '1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic issue;
        logic load_result;
    } npcs_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_empty;
    } npcs_status_t;

endpackage

// ===== sv/npcs_datapath.sv =====
// Datapath: palette memory, distance pipeline, best-match tracking, result register.
// Depends on npcs_pkg; driven by npcs_ctrl commands.
module npcs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  npcs_pkg::npcs_cmd_t           cmd,
    input  logic [7:0]                    entry_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output npcs_pkg::npcs_status_t        status,
    output logic [7:0]                    best_index
);
    import npcs_pkg::*;

    logic [3*COLOR_W-1:0] mem [PALETTE_SIZE];

    logic [COLOR_W-1:0]   q_r_reg, q_g_reg, q_b_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [IDX_W-1:0]     addr_next;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [3*COLOR_W-1:0] rdata_reg;
    logic [COLOR_W-1:0]   dr_reg, dg_reg, db_reg;
    logic [SQ_W-1:0]      sr_reg, sg_reg, sb_reg;

    logic [DIST_W-1:0]    bound_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [IDX_W-1:0]     result_reg;

    logic [COLOR_W-1:0]   e_r, e_g, e_b;
    logic [DIST_W-1:0]    dist_sum;
    logic                 better;
    logic                 wr_in_range;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign wr_in_range = ({1'b0, entry_index} < (FIELD_IDX_W+1)'(PALETTE_SIZE));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
        end
        rdata_reg <= mem[addr_reg];
    end

    assign addr_next = cmd.start ? '0 : (cmd.issue ? addr_reg + 1'b1 : addr_reg);

    assign e_r = rdata_reg[3*COLOR_W-1:2*COLOR_W];
    assign e_g = rdata_reg[2*COLOR_W-1:COLOR_W];
    assign e_b = rdata_reg[COLOR_W-1:0];

    assign dist_sum = DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
    assign better   = v3_reg && (dist_sum < bound_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_r_reg   <= red;
            q_g_reg   <= green;
            q_b_reg   <= blue;
            bound_reg <= BOUND_INIT;
            best_reg  <= '0;
        end
        else if (better)
        begin
            bound_reg <= dist_sum;
            best_reg  <= idx3_reg;
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dr_reg   <= abs_diff(q_r_reg, e_r);
        dg_reg   <= abs_diff(q_g_reg, e_g);
        db_reg   <= abs_diff(q_b_reg, e_b);
        sr_reg   <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sg_reg   <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sb_reg   <= SQ_W'(db_reg) * SQ_W'(db_reg);
        if (cmd.load_result)
        begin
            result_reg <= best_reg;
        end
    end

    assign status.last_issue = cmd.issue && (addr_reg == IDX_W'(PALETTE_SIZE - 1));
    assign status.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign best_index        = FIELD_IDX_W'(result_reg);

endmodule

// ===== sv/npcs_ctrl.sv =====
// Controller FSM: accepts words, sequences the palette walk, owns output valid.
// Depends on npcs_pkg; commands npcs_datapath.
module npcs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  npcs_pkg::npcs_status_t status,
    output npcs_pkg::npcs_cmd_t    cmd
);
    import npcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd.wr_en       = 1'b0;
        cmd.start       = 1'b0;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> status.pipe_empty)
        else $error("result loaded with distance pipeline busy");

    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_WALK))
        else $error("query did not start walk");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) && status.last_issue |=> (state_reg == ST_DRAIN))
        else $error("walk did not end after last entry");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== sv/nearest_palette_color_search_unit.sv =====
// Top level of the nearest palette color search unit.
// Depends on npcs_pkg, npcs_ctrl and npcs_datapath.
//
// A write word (action 0) stores one 24-bit palette entry and gives no result; an
// entry_index that lies beyond the palette is dropped. A query word
// (action 1) walks the palette memory one entry per cycle through a four-stage
// read/difference/square/compare pipeline and returns the index of the first
// entry with the least squared RGB distance. A query walks all PALETTE_SIZE
// entries through the single read port of the palette memory and stalls input
// until its result is loaded; the result then sits in an output register, and new
// words are taken while it waits. Query only after every entry has been written.
module nearest_palette_color_search_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] entry_index,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] best_index
);
    import npcs_pkg::*;

    npcs_cmd_t    cmd;
    npcs_status_t status;

    npcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    npcs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .status      (status),
        .best_index  (best_index)
    );

endmodule
